FILE: sv/bbp_pkg.sv
package bbp_pkg;

   localparam int MAX_INDEX_BITS_DEFAULT = 12;
   localparam int COUNT_WIDTH_DEFAULT    = 32;

   localparam int ADDR_WIDTH  = 32;
   localparam int FIELD_WIDTH = 32;
   localparam int INDEX_REG_WIDTH = 4;
   localparam int EFF_WIDTH   = 5;

   typedef logic [ADDR_WIDTH-1:0]      addr_type;
   typedef logic [FIELD_WIDTH-1:0]     field_type;
   typedef logic [INDEX_REG_WIDTH-1:0] index_reg_type;
   typedef logic [EFF_WIDTH-1:0]       eff_bits_type;
   typedef logic [1:0]                 ctr_type;

   localparam index_reg_type INDEX_BITS_RESET = index_reg_type'(12);
   localparam ctr_type CTR_MIN = 2'd0;
   localparam ctr_type CTR_MAX = 2'd3;

   // One resolved branch leaving the update stage.
   typedef struct packed {
      logic fire;
      logic predicted;
      logic taken;
   } outcome_type;

endpackage

FILE: sv/bbp_if.sv
interface bbp_req_if;
   logic              valid;
   logic              ready;
   bbp_pkg::addr_type branch_address;
   logic              taken;

   modport source (output valid, output branch_address, output taken, input ready);
   modport sink   (input valid, input branch_address, input taken, output ready);
endinterface

interface bbp_rsp_if;
   logic               valid;
   logic               ready;
   logic               predicted_taken;
   logic               prediction_correct;
   bbp_pkg::field_type total_branches;
   bbp_pkg::field_type right_taken_count;
   bbp_pkg::field_type wrong_taken_count;
   bbp_pkg::field_type right_not_taken_count;
   bbp_pkg::field_type wrong_not_taken_count;

   modport source (output valid, output predicted_taken, output prediction_correct,
                   output total_branches, output right_taken_count,
                   output wrong_taken_count, output right_not_taken_count,
                   output wrong_not_taken_count, input ready);
   modport sink   (input valid, input predicted_taken, input prediction_correct,
                   input total_branches, input right_taken_count,
                   input wrong_taken_count, input right_not_taken_count,
                   input wrong_not_taken_count, output ready);
endinterface

FILE: sv/bbp_counter_ram.sv
module bbp_counter_ram #(
   parameter int ADDR_BITS = bbp_pkg::MAX_INDEX_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output bbp_pkg::ctr_type rd_data,
   input  logic             wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  bbp_pkg::ctr_type wr_data
);
   import bbp_pkg::*;

   localparam int DEPTH = 1 << ADDR_BITS;

   ctr_type mem [DEPTH];
   ctr_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read before write: a read of the entry being written returns the old value.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/bbp_stats.sv
module bbp_stats #(
   parameter int COUNT_WIDTH = bbp_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bbp_pkg::outcome_type   outcome,
   output logic [COUNT_WIDTH-1:0] branch_tally,
   output logic [COUNT_WIDTH-1:0] hit_taken_tally,
   output logic [COUNT_WIDTH-1:0] miss_taken_tally,
   output logic [COUNT_WIDTH-1:0] hit_not_taken_tally,
   output logic [COUNT_WIDTH-1:0] miss_not_taken_tally
);
   import bbp_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] COUNT_FULL = '1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE  = COUNT_WIDTH'(1);

   logic [COUNT_WIDTH-1:0] branch_ff, branch_in;
   logic [COUNT_WIDTH-1:0] hit_t_ff, hit_t_in;
   logic [COUNT_WIDTH-1:0] miss_t_ff, miss_t_in;
   logic [COUNT_WIDTH-1:0] hit_nt_ff, hit_nt_in;
   logic [COUNT_WIDTH-1:0] miss_nt_ff, miss_nt_in;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
      return (v == COUNT_FULL) ? v : v + COUNT_ONE;
   endfunction

   always_comb begin
      branch_in  = branch_ff;
      hit_t_in   = hit_t_ff;
      miss_t_in  = miss_t_ff;
      hit_nt_in  = hit_nt_ff;
      miss_nt_in = miss_nt_ff;
      if (outcome.fire) begin
         branch_in = sat_inc(branch_ff);
         unique case ({outcome.predicted, outcome.taken})
            2'b11: hit_t_in   = sat_inc(hit_t_ff);
            2'b10: miss_t_in  = sat_inc(miss_t_ff);
            2'b01: miss_nt_in = sat_inc(miss_nt_ff);
            2'b00: hit_nt_in  = sat_inc(hit_nt_ff);
            default: branch_in = branch_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         branch_ff  <= '0;
         hit_t_ff   <= '0;
         miss_t_ff  <= '0;
         hit_nt_ff  <= '0;
         miss_nt_ff <= '0;
      end else begin
         branch_ff  <= branch_in;
         hit_t_ff   <= hit_t_in;
         miss_t_ff  <= miss_t_in;
         hit_nt_ff  <= hit_nt_in;
         miss_nt_ff <= miss_nt_in;
      end
   end

   assign branch_tally         = branch_ff;
   assign hit_taken_tally      = hit_t_ff;
   assign miss_taken_tally     = miss_t_ff;
   assign hit_not_taken_tally  = hit_nt_ff;
   assign miss_not_taken_tally = miss_nt_ff;

endmodule

FILE: sv/bimodal_branch_predictor_unit.sv
// Bimodal branch predictor with a table of 2-bit saturating counters.
//
// The req_channel carries one resolved branch per transfer: its address and
// its actual outcome. The rsp_channel returns exactly one result per branch,
// in order: the prediction made before the update, whether it was right, and
// saturating tallies that already include this branch.
// csr_write_enable with csr_write_data sets index_bits, the number of low
// address bits that index the table (0 acts as 1, values above
// MAX_INDEX_BITS act as MAX_INDEX_BITS). It should be written while idle.
//
// A branch accepted into the update stage moves on to the output register,
// from which its result is presented on rsp_channel.
// One branch per cycle is sustained while the receiver takes results: the
// counter RAM is read at acceptance and written back when the branch leaves
// the update stage, and a branch that hits the entry still being written
// takes the new value from a forwarding register.
// After reset the table is cleared one entry per cycle; req_channel.ready
// stays low meanwhile, while configuration writes are still taken.
// When the receiver stalls, the result waits in the output register, one
// further branch waits in the update stage and ready then falls.
module bimodal_branch_predictor_unit #(
   parameter int MAX_INDEX_BITS = bbp_pkg::MAX_INDEX_BITS_DEFAULT,
   parameter int COUNT_WIDTH    = bbp_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   bbp_req_if.sink                req_channel,
   bbp_rsp_if.source              rsp_channel,
   input  logic                   csr_write_enable,
   input  bbp_pkg::index_reg_type csr_write_data
);
   import bbp_pkg::*;

   typedef logic [MAX_INDEX_BITS-1:0] idx_type;

   localparam eff_bits_type EFF_MAX = eff_bits_type'(MAX_INDEX_BITS);
   localparam eff_bits_type EFF_MIN = eff_bits_type'(1);

   index_reg_type index_bits_ff;
   logic [MAX_INDEX_BITS:0] clr_ptr_ff;
   logic clearing;

   logic    s1_valid_ff;
   idx_type s1_idx_ff;
   logic    s1_taken_ff;
   logic    s1_fwd_ff;
   ctr_type s1_fwd_val_ff;

   logic rsp_valid_ff;
   logic rsp_pred_ff;
   logic rsp_correct_ff;

   eff_bits_type eff_bits;
   idx_type      mask;
   idx_type      req_idx;
   logic         out_free;
   logic         s1_fire;
   logic         accept;
   logic         fwd_in;
   ctr_type      rd_data;
   ctr_type      ctr_now;
   ctr_type      ctr_next;
   logic         pred;
   logic         wr_en;
   idx_type      wr_addr;
   ctr_type      wr_data;
   outcome_type  outcome;

   logic [COUNT_WIDTH-1:0] branch_tally;
   logic [COUNT_WIDTH-1:0] hit_taken_tally;
   logic [COUNT_WIDTH-1:0] miss_taken_tally;
   logic [COUNT_WIDTH-1:0] hit_not_taken_tally;
   logic [COUNT_WIDTH-1:0] miss_not_taken_tally;

   assign clearing = !clr_ptr_ff[MAX_INDEX_BITS];

   always_comb begin
      priority if (index_bits_ff == '0) begin
         eff_bits = EFF_MIN;
      end else if (eff_bits_type'(index_bits_ff) > EFF_MAX) begin
         eff_bits = EFF_MAX;
      end else begin
         eff_bits = eff_bits_type'(index_bits_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_INDEX_BITS; i++) begin
         mask[i] = (eff_bits_type'(i) < eff_bits);
      end
   end

   assign req_idx  = req_channel.branch_address[MAX_INDEX_BITS-1:0] & mask;
   assign out_free = !rsp_valid_ff || rsp_channel.ready;
   assign s1_fire  = s1_valid_ff && out_free;
   assign req_channel.ready = !clearing && (!s1_valid_ff || out_free);
   assign accept   = req_channel.valid && req_channel.ready;
   // The RAM returns the old value when the entry is written in the same cycle.
   assign fwd_in   = s1_fire && (s1_idx_ff == req_idx);

   assign ctr_now = s1_fwd_ff ? s1_fwd_val_ff : rd_data;
   assign pred    = ctr_now[1];

   always_comb begin
      if (s1_taken_ff) begin
         ctr_next = (ctr_now == CTR_MAX) ? ctr_now : ctr_now + 2'd1;
      end else begin
         ctr_next = (ctr_now == CTR_MIN) ? ctr_now : ctr_now - 2'd1;
      end
   end

   assign wr_en   = clearing || s1_fire;
   assign wr_addr = clearing ? clr_ptr_ff[MAX_INDEX_BITS-1:0] : s1_idx_ff;
   assign wr_data = clearing ? CTR_MIN : ctr_next;

   bbp_counter_ram #(
      .ADDR_BITS(MAX_INDEX_BITS)
   ) u_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (req_idx),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign outcome.fire      = s1_fire;
   assign outcome.predicted = pred;
   assign outcome.taken     = s1_taken_ff;

   bbp_stats #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_stats (
      .clock                (clock),
      .reset                (reset),
      .outcome              (outcome),
      .branch_tally         (branch_tally),
      .hit_taken_tally      (hit_taken_tally),
      .miss_taken_tally     (miss_taken_tally),
      .hit_not_taken_tally  (hit_not_taken_tally),
      .miss_not_taken_tally (miss_not_taken_tally)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         index_bits_ff <= INDEX_BITS_RESET;
         clr_ptr_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            index_bits_ff <= csr_write_data;
         end
         if (clearing) begin
            clr_ptr_ff <= clr_ptr_ff + 1'b1;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_channel.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_idx_ff     <= req_idx;
         s1_taken_ff   <= req_channel.taken;
         s1_fwd_ff     <= fwd_in;
         s1_fwd_val_ff <= ctr_next;
      end
      if (s1_fire) begin
         rsp_pred_ff    <= pred;
         rsp_correct_ff <= (pred == s1_taken_ff);
      end
   end

   // The tallies move only when a result enters the output register, so they
   // stay aligned with the result on display.
   assign rsp_channel.valid                 = rsp_valid_ff;
   assign rsp_channel.predicted_taken       = rsp_pred_ff;
   assign rsp_channel.prediction_correct    = rsp_correct_ff;
   assign rsp_channel.total_branches        = FIELD_WIDTH'(branch_tally);
   assign rsp_channel.right_taken_count     = FIELD_WIDTH'(hit_taken_tally);
   assign rsp_channel.wrong_taken_count     = FIELD_WIDTH'(miss_taken_tally);
   assign rsp_channel.right_not_taken_count = FIELD_WIDTH'(hit_not_taken_tally);
   assign rsp_channel.wrong_not_taken_count = FIELD_WIDTH'(miss_not_taken_tally);

   a_no_accept_while_clearing: assert property (
      @(posedge clock) disable iff (reset) clearing |-> !accept
   ) else $error("branch accepted during table clear");

   a_accept_fills_stage: assert property (
      @(posedge clock) disable iff (reset) accept |=> s1_valid_ff
   ) else $error("accepted branch lost before update stage");

   a_fire_fills_output: assert property (
      @(posedge clock) disable iff (reset) s1_fire |=> rsp_valid_ff
   ) else $error("updated branch did not reach output register");

   a_stalled_stage_holds: assert property (
      @(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(s1_idx_ff))
   ) else $error("update stage changed while stalled");

endmodule

FILE: bench/tb_bimodal_branch_predictor_unit.sv
`timescale 1ns / 1ps

module tb_bimodal_branch_predictor_unit;
   import bbp_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int TABLE_DEPTH  = 1 << MAX_INDEX_BITS_DEFAULT;
   localparam int HOT_BRANCHES = 8;

   typedef struct packed {
      logic      predicted_taken;
      logic      prediction_correct;
      field_type total_branches;
      field_type right_taken_count;
      field_type wrong_taken_count;
      field_type right_not_taken_count;
      field_type wrong_not_taken_count;
   } branch_result_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_write_enable = 1'b0;
   index_reg_type csr_write_data = INDEX_BITS_RESET;

   bbp_req_if req_if ();
   bbp_rsp_if rsp_if ();

   bimodal_branch_predictor_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (req_if),
      .rsp_channel      (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Predictor state, kept alongside the block.
   ctr_type       counter_shadow [TABLE_DEPTH];
   field_type     branch_tally;
   field_type     hit_taken_tally;
   field_type     miss_taken_tally;
   field_type     hit_not_taken_tally;
   field_type     miss_not_taken_tally;
   index_reg_type index_bits_shadow;

   branch_result_type pending_results [$];

   int        failures = 0;
   int        results_checked = 0;
   int        branches_sent = 0;
   int        width_writes = 0;
   int        cycle_count = 0;
   int        send_idle_pct = 0;
   int        stall_pct = 0;
   int        hold_off_cycles = 0;
   addr_type  hot_address [HOT_BRANCHES];
   logic      hot_bias [HOT_BRANCHES];
   addr_type  last_address = '0;

   always #5 clock = ~clock;

   function automatic field_type sat_inc(field_type v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic branch_result_type predict_branch(addr_type addr, logic taken);
      int unsigned       eff;
      field_type         mask;
      int unsigned       idx;
      ctr_type           ctr;
      branch_result_type res;
      eff = index_bits_shadow;
      if (eff < 1) begin
         eff = 1;
      end
      if (eff > MAX_INDEX_BITS_DEFAULT) begin
         eff = MAX_INDEX_BITS_DEFAULT;
      end
      mask = (field_type'(1) << eff) - 1'b1;
      idx = (addr & mask) & (TABLE_DEPTH - 1);
      ctr = counter_shadow[idx];
      res.predicted_taken = (ctr >= 2'd2);
      res.prediction_correct = (res.predicted_taken == taken);
      if (res.predicted_taken) begin
         if (taken) hit_taken_tally = sat_inc(hit_taken_tally);
         else miss_taken_tally = sat_inc(miss_taken_tally);
      end else begin
         if (taken) miss_not_taken_tally = sat_inc(miss_not_taken_tally);
         else hit_not_taken_tally = sat_inc(hit_not_taken_tally);
      end
      branch_tally = sat_inc(branch_tally);
      if (taken && ctr != CTR_MAX) begin
         ctr = ctr + 1'b1;
      end else if (!taken && ctr != CTR_MIN) begin
         ctr = ctr - 1'b1;
      end
      counter_shadow[idx] = ctr;
      res.total_branches = branch_tally;
      res.right_taken_count = hit_taken_tally;
      res.wrong_taken_count = miss_taken_tally;
      res.right_not_taken_count = hit_not_taken_tally;
      res.wrong_not_taken_count = miss_not_taken_tally;
      return res;
   endfunction

   function automatic void check_field(string name, field_type expected, field_type actual);
      if (expected !== actual) begin
         failures++;
         $error("%s: expected %0d, got %0d", name, expected, actual);
      end
   endfunction

   // Results are checked before the new branch is predicted; a result can
   // never belong to a branch accepted at the same edge.
   always @(posedge clock) begin
      branch_result_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
      if (!reset) begin
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
               failures++;
               $error("result transfer with no branch outstanding");
            end else begin
               want = pending_results.pop_front();
               check_field("predicted_taken", field_type'(want.predicted_taken),
                           field_type'(rsp_if.predicted_taken));
               check_field("prediction_correct", field_type'(want.prediction_correct),
                           field_type'(rsp_if.prediction_correct));
               check_field("total_branches", want.total_branches, rsp_if.total_branches);
               check_field("right_taken_count", want.right_taken_count,
                           rsp_if.right_taken_count);
               check_field("wrong_taken_count", want.wrong_taken_count,
                           rsp_if.wrong_taken_count);
               check_field("right_not_taken_count", want.right_not_taken_count,
                           rsp_if.right_not_taken_count);
               check_field("wrong_not_taken_count", want.wrong_not_taken_count,
                           rsp_if.wrong_not_taken_count);
               results_checked++;
            end
         end
         if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
            pending_results.push_back(predict_branch(req_if.branch_address, req_if.taken));
         end
      end
   end

   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_if.ready <= 1'b0;
         hold_off_cycles--;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_branch(addr_type addr, logic taken);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.branch_address <= addr;
      req_if.taken <= taken;
      last_address = addr;
      do @(posedge clock); while (!(req_if.valid === 1'b1 && req_if.ready === 1'b1));
      branches_sent++;
   endtask

   // Drops valid and waits until every outstanding result has arrived.
   task automatic drain_pipeline();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_index_bits(index_reg_type value);
      drain_pipeline();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      index_bits_shadow = value;
      width_writes++;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Mostly a few trained branches with a strong bias, some repeats of the
   // previous address (back-to-back hits on one entry) and some noise.
   function automatic void pick_branch(output addr_type addr, output logic taken);
      int r;
      int h;
      r = $urandom_range(99);
      h = $urandom_range(HOT_BRANCHES - 1);
      if (r < 60) begin
         addr = hot_address[h];
         taken = ($urandom_range(99) < 85) ? hot_bias[h] : !hot_bias[h];
      end else if (r < 75) begin
         addr = last_address;
         taken = 1'($urandom_range(1));
      end else begin
         addr = $urandom;
         taken = 1'($urandom_range(1));
      end
   endfunction

   function automatic index_reg_type width_setting(int k);
      case (k % 12)
         0:       return 4'd1;
         1:       return 4'd4;
         2:       return 4'd12;
         3:       return 4'd0;
         4:       return 4'd15;
         5:       return 4'd2;
         6:       return 4'd7;
         7:       return 4'd13;
         8:       return 4'd9;
         9:       return 4'd3;
         10:      return 4'd11;
         default: return 4'd6;
      endcase
   endfunction

   task automatic test_counter_saturation();
      int n;
      send_idle_pct = 0;
      stall_pct = 0;
      write_index_bits(INDEX_BITS_RESET);
      for (n = 0; n < 5; n++) send_branch(32'h0000_0000, 1'b1);
      for (n = 0; n < 5; n++) send_branch(32'h0000_0000, 1'b0);
      send_branch(32'hFFFF_FFFF, 1'b1);
      send_branch(32'hFFFF_F000, 1'b1);
   endtask

   task automatic test_index_width_extremes();
      // Zero acts as one bit; widths above the table size are clamped.
      write_index_bits(4'd0);
      send_branch(32'h0000_0002, 1'b1);
      send_branch(32'h0000_0004, 1'b1);
      send_branch(32'h0000_0001, 1'b0);
      write_index_bits(4'd15);
      send_branch(32'h0000_1000, 1'b0);
      send_branch(32'h0000_0FFF, 1'b0);
      write_index_bits(4'd13);
      send_branch(32'h0000_2ABC, 1'b1);
      // The table is not cleared on a width change.
      write_index_bits(4'd1);
      send_branch(32'h0000_0003, 1'b1);
      send_branch(32'h0000_0001, 1'b1);
   endtask

   task automatic test_receiver_backpressure();
      int n;
      addr_type a;
      logic t;
      drain_pipeline();
      send_idle_pct = 0;
      stall_pct = 0;
      hold_off_cycles = 80;
      for (n = 0; n < 24; n++) begin
         pick_branch(a, t);
         send_branch(a, t);
      end
      drain_pipeline();
   endtask

   task automatic test_random_traffic(int sender_idle, int receiver_stall, int phase);
      int k;
      int n;
      addr_type a;
      logic t;
      send_idle_pct = sender_idle;
      stall_pct = receiver_stall;
      for (k = 0; k < 4; k++) begin
         write_index_bits(width_setting(phase * 4 + k));
         for (n = 0; n < 40; n++) begin
            pick_branch(a, t);
            send_branch(a, t);
         end
      end
   endtask

   initial begin
      int k;
      req_if.valid = 1'b0;
      req_if.branch_address = '0;
      req_if.taken = 1'b0;
      rsp_if.ready = 1'b0;
      for (k = 0; k < TABLE_DEPTH; k++) counter_shadow[k] = CTR_MIN;
      branch_tally = '0;
      hit_taken_tally = '0;
      miss_taken_tally = '0;
      hit_not_taken_tally = '0;
      miss_not_taken_tally = '0;
      index_bits_shadow = INDEX_BITS_RESET;
      for (k = 0; k < HOT_BRANCHES; k++) begin
         hot_address[k] = $urandom;
         hot_bias[k] = 1'($urandom_range(1));
      end
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      test_counter_saturation();
      test_index_width_extremes();
      test_receiver_backpressure();
      test_random_traffic(32, 63, 0);
      test_random_traffic(63, 32, 1);
      test_random_traffic(0, 0, 2);
      drain_pipeline();

      if (pending_results.size() != 0) begin
         failures++;
         $error("%0d expected results never arrived", pending_results.size());
      end
      $display("Sent %0d branches and checked %0d results across %0d index-width writes,",
               branches_sent, results_checked, width_writes);
      $display("with random idling on both channels and one long stall of the result side.");
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
